### sv/hdcs_pkg.sv
package hdcs_pkg;

    localparam int DIMENSION_DEF = 1024;
    localparam int ENTRIES_DEF   = 16;

    localparam int VEC_W     = 64;
    localparam int SCORE_W   = 12;
    localparam int POP_W     = 7;
    localparam int ENT_MAX_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [SCORE_W:0] ACC_MAX = 13'sd2047;
    localparam logic signed [SCORE_W:0] ACC_MIN = -13'sd2048;

    // one-hot sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    // one scored entry, handed to the best-entry tracker
    typedef struct packed {
        logic                       vld;
        logic                       first;
        logic                       last;
        logic                       report;
        logic                       ent_valid;
        logic [ENT_MAX_W-1:0]       ent;
        logic signed [SCORE_W-1:0]  score;
    } t_cand;

    // dot + (64 - 2*pop), saturated to the 12-bit score range
    function automatic logic signed [SCORE_W-1:0] sat_acc(
        input logic signed [SCORE_W-1:0] dot,
        input logic [POP_W-1:0]          pop
    );
        logic signed [SCORE_W:0] s;
        s = 13'(dot) + 13'sd64 - $signed({5'd0, pop, 1'b0});
        if (s > ACC_MAX) begin
            s = ACC_MAX;
        end else if (s < ACC_MIN) begin
            s = ACC_MIN;
        end
        return 12'(s);
    endfunction

endpackage

### sv/hdcs_chunk_mem.sv
module hdcs_chunk_mem #(
    parameter int DEPTH = hdcs_pkg::ENTRIES_DEF * (hdcs_pkg::DIMENSION_DEF / 64)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic [hdcs_pkg::VEC_W-1:0]        i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic [hdcs_pkg::VEC_W-1:0]        o_rd_data
);

    logic [hdcs_pkg::VEC_W-1:0] mem [DEPTH];
    logic [hdcs_pkg::VEC_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rdata;

endmodule

### sv/hdcs_dot_mem.sv
module hdcs_dot_mem #(
    parameter int ENTRIES = hdcs_pkg::ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(ENTRIES)-1:0]           i_rd_addr,
    input  logic                                 i_we,
    input  logic [$clog2(ENTRIES)-1:0]           i_wr_addr,
    input  logic signed [hdcs_pkg::SCORE_W-1:0]  i_wr_data,
    output logic signed [hdcs_pkg::SCORE_W-1:0]  o_rd_data
);

    logic signed [hdcs_pkg::SCORE_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]                  r_vld;   // entry holds a written sum
    logic signed [hdcs_pkg::SCORE_W-1:0] r_rdata;
    logic                                r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_rd_addr];
        end
    end

    // never-written sums read as zero
    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

### sv/hdcs_best.sv
module hdcs_best (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hdcs_pkg::t_cand                      i_cand,
    output logic                                 o_strobe,
    output logic [3:0]                           o_best_entry,
    output logic signed [hdcs_pkg::SCORE_W-1:0]  o_best_score,
    output logic                                 o_found
);

    logic                                r_any;
    logic [hdcs_pkg::ENT_MAX_W-1:0]      r_best;
    logic signed [hdcs_pkg::SCORE_W-1:0] r_score;

    logic                                cur_any;
    logic                                take;
    logic                                n_any;
    logic [hdcs_pkg::ENT_MAX_W-1:0]      n_best;
    logic signed [hdcs_pkg::SCORE_W-1:0] n_score;

    // strict greater-than keeps the lowest index on ties
    always_comb begin
        cur_any = i_cand.first ? 1'b0 : r_any;
        take    = i_cand.vld && i_cand.ent_valid
                  && (!cur_any || (i_cand.score > r_score));
        n_any   = take || cur_any;
        n_best  = take ? i_cand.ent : r_best;
        n_score = take ? i_cand.score : r_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            if (i_cand.vld) begin
                r_any <= n_any;
            end
            o_strobe <= i_cand.vld && i_cand.last && i_cand.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cand.vld) begin
            r_best  <= n_best;
            r_score <= n_score;
        end
        if (i_cand.vld && i_cand.last) begin
            o_best_entry <= n_any ? 4'(n_best) : 4'd0;
            o_best_score <= n_any ? n_score : '0;
            o_found      <= n_any;
        end
    end

endmodule

### sv/hdc_associative_nearest_search.sv
// Write beat: busy stays low, the chunk is in memory at the accepting edge.
// Query beat: busy stays high while the sequencer walks every entry and drains, so the next
//   beat waits for it; the chunk memory gives one entry per cycle, so that read port
//   sets the rate. A final chunk puts one result on the outputs with o_strobe, registered
//   after the last entry leaves the accumulate stage. The receiver cannot stall.
// Synchronous active-low reset clears valid flags, partial sums and the sequencer.
module hdc_associative_nearest_search #(
    parameter int DIMENSION = hdcs_pkg::DIMENSION_DEF,
    parameter int ENTRIES   = hdcs_pkg::ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_opcode,
    input  logic [3:0]                           i_entry_index,
    input  logic [3:0]                           i_chunk_index,
    input  logic [hdcs_pkg::VEC_W-1:0]           i_vector_bits,
    output logic                                 o_strobe,
    output logic [3:0]                           o_best_entry,
    output logic signed [hdcs_pkg::SCORE_W-1:0]  o_best_score,
    output logic                                 o_found
);

    localparam int NCHUNK = DIMENSION / 64;
    localparam int DEPTH  = ENTRIES * NCHUNK;
    localparam int EW     = $clog2(ENTRIES);
    localparam int AW     = $clog2(DEPTH);
    localparam logic [EW-1:0] LAST_ENT = EW'(ENTRIES - 1);

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    logic          accept;
    logic          chunk_ok;
    logic          entry_ok;
    logic          wr_en;
    logic          qry_go;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign accept   = start && !busy;
    assign chunk_ok = int'(i_chunk_index) < NCHUNK;
    assign entry_ok = int'(i_entry_index) < ENTRIES;
    assign wr_en    = accept && (i_opcode == hdcs_pkg::OP_WRITE) && chunk_ok && entry_ok;
    assign qry_go   = accept && (i_opcode == hdcs_pkg::OP_QUERY) && chunk_ok;
    assign wr_addr  = AW'(int'(i_entry_index) * NCHUNK + int'(i_chunk_index));

    // ---------------------------------------------------------------
    // Sequencer: walks the entries for one query beat, then waits
    // for the last entry to leave the accumulate stage.
    // ---------------------------------------------------------------
    hdcs_pkg::t_state            r_state;
    hdcs_pkg::t_state            n_state;
    logic [EW-1:0]               r_issue;
    logic [EW-1:0]               n_issue;
    logic [3:0]                  r_chunk;
    logic [hdcs_pkg::VEC_W-1:0]  r_bits;
    logic                        r_clear;   // chunk zero: start sums from zero
    logic                        r_final;   // last chunk: report a result
    logic [ENTRIES-1:0]          r_entry_valid;

    // pipeline: issue -> s1 (memory data) -> s2 (popcount) -> accumulate
    logic                                r_s1_vld;
    logic [EW-1:0]                       r_s1_ent;
    logic                                r_s2_vld;
    logic [EW-1:0]                       r_s2_ent;
    logic [hdcs_pkg::POP_W-1:0]          r_s2_pop;
    logic signed [hdcs_pkg::SCORE_W-1:0] r_s2_dot;

    logic                                issue_vld;
    logic [hdcs_pkg::VEC_W-1:0]          chunk_rd;
    logic signed [hdcs_pkg::SCORE_W-1:0] dot_rd;
    logic signed [hdcs_pkg::SCORE_W-1:0] acc;
    logic                                s2_last;
    hdcs_pkg::t_cand                     cand;

    assign busy      = (r_state != hdcs_pkg::ST_IDLE);
    assign issue_vld = (r_state == hdcs_pkg::ST_ISSUE);
    assign rd_addr   = AW'(int'(r_issue) * NCHUNK + int'(r_chunk));
    assign s2_last   = r_s2_vld && (r_s2_ent == LAST_ENT);

    always_comb begin
        n_state = r_state;
        n_issue = r_issue;
        case (r_state)
            hdcs_pkg::ST_IDLE: begin
                if (qry_go) begin
                    n_state = hdcs_pkg::ST_ISSUE;
                    n_issue = '0;
                end
            end
            hdcs_pkg::ST_ISSUE: begin
                if (r_issue == LAST_ENT) begin
                    n_state = hdcs_pkg::ST_DRAIN;
                end else begin
                    n_issue = r_issue + EW'(1);
                end
            end
            hdcs_pkg::ST_DRAIN: begin
                if (s2_last) begin
                    n_state = hdcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hdcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hdcs_pkg::ST_IDLE;
            r_issue       <= '0;
            r_entry_valid <= '0;
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_s1_vld <= issue_vld;
            r_s2_vld <= r_s1_vld;
            if (wr_en) begin
                r_entry_valid[EW'(i_entry_index)] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (qry_go) begin
            r_chunk <= i_chunk_index;
            r_bits  <= i_vector_bits;
            r_clear <= (i_chunk_index == 4'd0);
            r_final <= (int'(i_chunk_index) == NCHUNK - 1);
        end
        r_s1_ent <= r_issue;
        r_s2_ent <= r_s1_ent;
        // elements that differ count -1, equal ones +1
        r_s2_pop <= 7'($countones(chunk_rd ^ r_bits));
        r_s2_dot <= r_clear ? '0 : dot_rd;
    end

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    hdcs_chunk_mem #(
        .DEPTH     (DEPTH)
    ) u_chunk_mem (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_vector_bits),
        .i_rd_addr (rd_addr),
        .o_rd_data (chunk_rd)
    );

    // read at issue, written back from s2 at a different entry
    hdcs_dot_mem #(
        .ENTRIES   (ENTRIES)
    ) u_dot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_issue),
        .i_we      (r_s2_vld),
        .i_wr_addr (r_s2_ent),
        .i_wr_data (acc),
        .o_rd_data (dot_rd)
    );

    // ---------------------------------------------------------------
    // Accumulate and pick the best valid entry
    // ---------------------------------------------------------------
    assign acc = hdcs_pkg::sat_acc(r_s2_dot, r_s2_pop);

    always_comb begin
        cand.vld       = r_s2_vld;
        cand.first     = (r_s2_ent == '0);
        cand.last      = (r_s2_ent == LAST_ENT);
        cand.report    = r_final;
        cand.ent_valid = r_entry_valid[r_s2_ent];
        cand.ent       = hdcs_pkg::ENT_MAX_W'(r_s2_ent);
        cand.score     = acc;
    end

    hdcs_best u_best (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand       (cand),
        .o_strobe     (o_strobe),
        .o_best_entry (o_best_entry),
        .o_best_score (o_best_score),
        .o_found      (o_found)
    );

endmodule

### test/hdc_associative_nearest_search_test.sv
`timescale 1ns / 100ps

module hdc_associative_nearest_search_test;

    localparam int   VEC_W    = hdcs_pkg::VEC_W;
    localparam int   SCORE_W  = hdcs_pkg::SCORE_W;
    localparam logic OP_WRITE = hdcs_pkg::OP_WRITE;
    localparam logic OP_QUERY = hdcs_pkg::OP_QUERY;

    localparam int ENTRIES  = hdcs_pkg::ENTRIES_DEF;
    localparam int NCHUNK   = hdcs_pkg::DIMENSION_DEF / VEC_W;
    localparam int LAST_CHK = NCHUNK - 1;
    localparam int LATENCY  = ENTRIES + 3;

    // stimulus stops once both counts are reached
    localparam int BEAT_GOAL   = 850;
    localparam int RESULT_GOAL = 40;
    // no idle gaps once this many beats are queued
    localparam int QUIET_FROM  = 780;

    // one command beat as queued for the driver
    typedef struct {
        logic             op;
        logic [3:0]       ent;
        logic [3:0]       chk;
        logic [VEC_W-1:0] bits;
        int               gap;    // idle cycles before this beat
        bit               drain;  // hold until every pending match has come
    } t_beat;

    // one expected nearest-entry result
    typedef struct {
        logic [3:0]                 ent;
        logic signed [SCORE_W-1:0]  score;
        logic                       found;
    } t_match;

    logic                       i_clk;
    logic                       i_rst_n       = 1'b0;
    logic                       start         = 1'b0;
    logic                       busy;
    logic                       i_opcode      = OP_WRITE;
    logic [3:0]                 i_entry_index = '0;
    logic [3:0]                 i_chunk_index = '0;
    logic [VEC_W-1:0]           i_vector_bits = '0;
    logic                       o_strobe;
    logic [3:0]                 o_best_entry;
    logic signed [SCORE_W-1:0]  o_best_score;
    logic                       o_found;

    t_beat  beat_q[$];
    t_match match_q[$];

    // predictor state, updated at each accepted beat
    logic [VEC_W-1:0] pred_mem [ENTRIES][NCHUNK];
    bit               pred_valid [ENTRIES];
    int               pred_dot [ENTRIES];

    // stimulus-side copy of the item memory, used to aim queries and build copied writes
    logic [VEC_W-1:0] shadow_mem [ENTRIES][NCHUNK];

    int n_beats;      // beats queued
    int n_results;    // final query chunks queued
    int beats_done;   // beats accepted by the block
    int fail_cnt;

    // driver bookkeeping
    t_beat cur_beat;
    t_beat next_beat;
    bit    have_next;
    int    gap_left;

    hdc_associative_nearest_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_chunk_index (i_chunk_index),
        .i_vector_bits (i_vector_bits),
        .o_strobe      (o_strobe),
        .o_best_entry  (o_best_entry),
        .o_best_score  (o_best_score),
        .o_found       (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------
    // Predictor: write stores a chunk and marks the entry valid; a query
    // chunk adds 64 - 2*popcount(xor) to every entry's saturating sum,
    // chunk zero clears the sums first, and the final chunk reports the
    // lowest-indexed valid entry holding the largest sum.
    // -------------------------------------------------------------------
    task automatic score_beat(input t_beat b);
        int     s;
        bit     any;
        int     win;
        int     win_score;
        t_match m;
        if (b.op == OP_WRITE) begin
            pred_mem[b.ent][b.chk] = b.bits;
            pred_valid[b.ent]      = 1'b1;
        end else begin
            if (b.chk == 0) begin
                foreach (pred_dot[e]) pred_dot[e] = 0;
            end
            for (int e = 0; e < ENTRIES; e++) begin
                s = pred_dot[e] + 64 - 2 * $countones(pred_mem[e][b.chk] ^ b.bits);
                if (s > 2047) s = 2047;
                if (s < -2048) s = -2048;
                pred_dot[e] = s;
            end
            if (b.chk == LAST_CHK) begin
                any       = 1'b0;
                win       = 0;
                win_score = 0;
                for (int e = 0; e < ENTRIES; e++) begin
                    // strict compare keeps the lowest index on a tie
                    if (pred_valid[e] && (!any || pred_dot[e] > win_score)) begin
                        any       = 1'b1;
                        win       = e;
                        win_score = pred_dot[e];
                    end
                end
                m.ent   = 4'(win);
                m.score = SCORE_W'(win_score);
                m.found = any;
                match_q.insert(match_q.size(), m);
            end
        end
    endtask

    // -------------------------------------------------------------------
    // Driver: a beat moves at an edge with start high and busy low. The
    // next beat is put up at that same edge, so start stays high across
    // back-to-back beats and gets one assignment per edge.
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                score_beat(cur_beat);
                beats_done++;
            end
            if (start && busy) begin
                // block still working, hold the beat
            end else begin
                if (!have_next && beat_q.size() != 0) begin
                    next_beat = beat_q.pop_front();
                    have_next = 1'b1;
                    gap_left  = next_beat.gap;
                end
                if (have_next && gap_left == 0 &&
                    !(next_beat.drain && match_q.size() != 0)) begin
                    cur_beat      = next_beat;
                    have_next     = 1'b0;
                    start         <= 1'b1;
                    i_opcode      <= next_beat.op;
                    i_entry_index <= next_beat.ent;
                    i_chunk_index <= next_beat.chk;
                    i_vector_bits <= next_beat.bits;
                end else begin
                    if (have_next && gap_left > 0) gap_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // Monitor: every strobe is checked against the oldest expected match.
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_match m;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (match_q.size() == 0) begin
                $error("result with none expected: entry %0d score %0d found %0b",
                       o_best_entry, o_best_score, o_found);
                fail_cnt++;
            end else begin
                m = match_q.pop_front();
                if (o_best_entry !== m.ent) begin
                    $error("best_entry: expected %0d, got %0d", m.ent, o_best_entry);
                    fail_cnt++;
                end
                if (o_best_score !== m.score) begin
                    $error("best_score: expected %0d, got %0d", m.score, o_best_score);
                    fail_cnt++;
                end
                if (o_found !== m.found) begin
                    $error("found: expected %0b, got %0b", m.found, o_found);
                    fail_cnt++;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // Stimulus helpers
    // -------------------------------------------------------------------
    function automatic logic [VEC_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // n scattered bit flips (may overlap)
    function automatic logic [VEC_W-1:0] flip_mask(input int n);
        logic [VEC_W-1:0] m;
        m = '0;
        for (int i = 0; i < n; i++) m[$urandom_range(0, VEC_W - 1)] = 1'b1;
        return m;
    endfunction

    function automatic int pick_gap(input bit gapped);
        if (!gapped || n_beats >= QUIET_FROM || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(1, 8);
    endfunction

    task automatic add_beat(input logic op, input int ent, input int chk,
                            input logic [VEC_W-1:0] bits, input bit gapped,
                            input bit drain);
        t_beat b;
        b.op    = op;
        b.ent   = 4'(ent);
        b.chk   = 4'(chk);
        b.bits  = bits;
        b.gap   = pick_gap(gapped);
        b.drain = drain;
        beat_q.insert(beat_q.size(), b);
        n_beats++;
        if (op == OP_WRITE) shadow_mem[ent][chk] = bits;
        else if (chk == LAST_CHK) n_results++;
    endtask

    // data for a random write: fresh, a copy of another entry, solid, or near
    function automatic logic [VEC_W-1:0] write_data(input int chk);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return rand64();
        if (roll < 6) return shadow_mem[$urandom_range(0, ENTRIES - 1)][chk];
        if (roll == 6) return '1;
        if (roll == 7) return '0;
        return shadow_mem[$urandom_range(0, ENTRIES - 1)][chk]
               ^ flip_mask($urandom_range(1, 6));
    endfunction

    // all entries' chunk c; target entry gets tgt_bits, the rest other_bits
    task automatic set_column(input int c, input int tgt,
                              input logic [VEC_W-1:0] tgt_bits,
                              input logic [VEC_W-1:0] other_bits);
        for (int e = 0; e < ENTRIES; e++)
            add_beat(OP_WRITE, e, c, (e == tgt) ? tgt_bits : other_bits, 1'b0, 1'b0);
    endtask

    task automatic repeat_query(input int c, input logic [VEC_W-1:0] bits, input int n);
        for (int i = 0; i < n; i++) add_beat(OP_QUERY, 0, c, bits, 1'b0, 1'b0);
    endtask

    // drive the sums into both rails and back
    task automatic saturation_run();
        int tgt;
        tgt = $urandom_range(0, ENTRIES - 1);
        set_column(3, tgt, '0, '1);
        set_column(LAST_CHK, tgt, '0, '0);
        // target climbs to the top rail, the rest sink to the bottom one
        add_beat(OP_QUERY, 0, 0, rand64(), 1'b0, 1'b0);
        repeat_query(3, '0, 34);
        add_beat(OP_QUERY, 0, LAST_CHK, '0, 1'b0, 1'b0);
        // swing back without clearing: the rest climb from the bottom rail
        repeat_query(3, '1, 33);
        add_beat(OP_QUERY, 0, LAST_CHK, '0, 1'b0, 1'b0);
        // everything to the bottom rail, all tie
        repeat_query(LAST_CHK, '1, 35);
    endtask

    // clone one entry into another, giving exact ties
    task automatic clone_entry(input bit gapped);
        int src;
        int dst;
        src = $urandom_range(0, ENTRIES - 1);
        dst = $urandom_range(0, ENTRIES - 1);
        for (int c = 0; c < NCHUNK; c++)
            add_beat(OP_WRITE, dst, c, shadow_mem[src][c], gapped, 1'b0);
    endtask

    // full query, mostly aimed near one entry
    task automatic clean_query(input bit gapped, input bit drain);
        int  tgt;
        int  flips;
        bit  aimed;
        logic [VEC_W-1:0] v;
        tgt   = $urandom_range(0, ENTRIES - 1);
        flips = $urandom_range(0, 24);
        aimed = ($urandom_range(0, 4) != 0);
        for (int c = 0; c < NCHUNK; c++) begin
            v = aimed ? (shadow_mem[tgt][c] ^ flip_mask(flips)) : rand64();
            add_beat(OP_QUERY, 0, c, v, gapped, drain && c == 0);
        end
    endtask

    // out of order, repeated or truncated chunks
    task automatic broken_query(input bit gapped);
        int len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
            add_beat(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, LAST_CHK - 1),
                     rand64(), gapped, 1'b0);
        if ($urandom_range(0, 1))
            add_beat(OP_QUERY, $urandom_range(0, 15), LAST_CHK, rand64(), gapped, 1'b0);
    endtask

    // -------------------------------------------------------------------
    // Stimulus and end of run
    // -------------------------------------------------------------------
    initial begin
        logic [VEC_W-1:0] v;
        bit gapped;
        bit drain;
        bit sat_done;
        int roll;
        int nw;

        foreach (pred_valid[e]) pred_valid[e] = 1'b0;
        foreach (pred_dot[e]) pred_dot[e] = 0;
        n_beats    = 0;
        n_results  = 0;
        beats_done = 0;
        fail_cnt   = 0;
        have_next  = 1'b0;
        gap_left   = 0;
        sat_done   = 1'b0;

        // Preload every chunk of every entry so no query reads an unwritten
        // word. Entries 0 and 1 are equal (tie), 15 all ones, 13/14 alternate.
        for (int e = 0; e < ENTRIES; e++) begin
            gapped = $urandom_range(0, 1);
            for (int c = 0; c < NCHUNK; c++) begin
                if (e <= 1)       v = '0;
                else if (e == 15) v = '1;
                else if (e == 14) v = {16{4'hA}};
                else if (e == 13) v = {16{4'h5}};
                else              v = rand64();
                add_beat(OP_WRITE, e, c, v, gapped, 1'b0);
            end
        end

        // Directed: all-zero query after a full pause; entries 0 and 1 tie at
        // the top score and the lower index must win.
        for (int c = 0; c < NCHUNK; c++) add_beat(OP_QUERY, 0, c, '0, 1'b0, c == 0);
        // final chunk alone keeps adding onto the previous sums
        add_beat(OP_QUERY, 0, LAST_CHK, '1, 1'b0, 1'b0);
        // hold the write until that result is out
        add_beat(OP_WRITE, 2, 7, '1, 1'b0, 1'b1);
        // chunk zero clears, then straight to the final chunk
        add_beat(OP_QUERY, 0, 0, '1, 1'b0, 1'b0);
        add_beat(OP_QUERY, 0, LAST_CHK, '1, 1'b0, 1'b0);

        // Random part, mostly complete queries with random content.
        while (n_beats < BEAT_GOAL || n_results < RESULT_GOAL) begin
            gapped = $urandom_range(0, 1);
            drain  = ($urandom_range(0, 19) == 0) && (n_beats < QUIET_FROM);
            roll   = $urandom_range(0, 19);
            if (!sat_done && n_beats > 450) begin
                saturation_run();
                sat_done = 1'b1;
            end else if (roll < 3) begin
                nw = $urandom_range(1, 4);
                for (int i = 0; i < nw; i++) begin
                    roll = $urandom_range(0, LAST_CHK);
                    add_beat(OP_WRITE, $urandom_range(0, ENTRIES - 1), roll,
                             write_data(roll), gapped, 1'b0);
                end
            end else if (roll == 3) begin
                clone_entry(gapped);
            end else if (roll < 7) begin
                broken_query(gapped);
            end else begin
                clean_query(gapped, drain);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_done != n_beats) @(posedge i_clk);
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
